// ----- rtl/core/sacs_pkg.sv -----
// Shared types and constants of the self-addressed SPI configuration slave.
package sacs_pkg;

	// Field widths
	localparam int unsigned CmdW     = 2;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned BandW    = 6;
	localparam int unsigned PrescW   = 4;
	localparam int unsigned GainW    = 6;
	localparam int unsigned IntegW   = 5;
	localparam int unsigned CountW   = 32;

	// Event kinds
	typedef enum logic [CmdW-1:0] {
		CMD_SELECT = 2'd0,
		CMD_BYTE   = 2'd1,
		CMD_HOLD   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Target field of a self-addressed word (top two bits)
	typedef enum logic [1:0] {
		TGT_BANDPASS  = 2'b00,
		TGT_PRESCALER = 2'b01,
		TGT_GAIN      = 2'b10,
		TGT_EXTENDED  = 2'b11
	} target_t;

	// Bit 5 of an extended word picks the integrator or the channel
	localparam logic TGT_EXT_INTEGRATOR = 1'b0;

	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [ByteW-1:0] data_value;
	} item_t;

	typedef struct packed {
		logic [BandW-1:0]  bandpass_code;
		logic [PrescW-1:0] prescaler_code;
		logic              output_hiz;
		logic [GainW-1:0]  gain_code;
		logic [IntegW-1:0] integrator_code;
		logic              channel_sel;
		logic [ByteW-1:0]  last_word;
		logic [CountW-1:0] word_count;
		logic [CountW-1:0] txn_count;
		logic [CountW-1:0] hold_edge_count;
		logic              selected;
		logic              hold_level;
	} result_t;

endpackage

// ----- rtl/core/sacs_if.sv -----
// Valid/ready stream interfaces for the event and snapshot channels.
interface sacs_item_if;
	import sacs_pkg::*;
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sacs_result_if;
	import sacs_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/spi_self_addressed_config_slave_unit.sv -----
// SPI configuration slave: decodes self-addressed words and reports a register snapshot.
//
// Every accepted event (chip-select level, SPI byte or hold-pin level) yields exactly one
// register snapshot. An event is captured in an input register; when it commits from there,
// the register file is updated and the snapshot loaded into the output register, from
// which the result leaves. One event is taken every clock cycle; the state update in
// stage 1 sets that rate, and it only drops when the result channel stalls, in which
// case both stages hold.
module spi_self_addressed_config_slave_unit
	import sacs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	sacs_item_if.sink            item,
	sacs_result_if.source        result
);

	// Pipeline registers
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;

	// Architectural state
	logic              select_q;
	logic              byte_waiting_q;
	logic [ByteW-1:0]  pending_q;
	logic [ByteW-1:0]  last_word_q;
	logic [BandW-1:0]  bandpass_q;
	logic [PrescW-1:0] prescaler_q;
	logic              hiz_q;
	logic [GainW-1:0]  gain_q;
	logic [IntegW-1:0] integ_q;
	logic              channel_q;
	logic [CountW-1:0] word_count_q;
	logic [CountW-1:0] txn_count_q;
	logic              hold_q;
	logic [CountW-1:0] hold_count_q;

	// Next-state values for the event in stage 1
	logic              select_d;
	logic              byte_waiting_d;
	logic [ByteW-1:0]  pending_d;
	logic [ByteW-1:0]  last_word_d;
	logic [BandW-1:0]  bandpass_d;
	logic [PrescW-1:0] prescaler_d;
	logic              hiz_d;
	logic [GainW-1:0]  gain_d;
	logic [IntegW-1:0] integ_d;
	logic              channel_d;
	logic [CountW-1:0] word_count_d;
	logic [CountW-1:0] txn_count_d;
	logic              hold_d;
	logic [CountW-1:0] hold_count_d;

	logic    advance;
	logic    commit;
	logic    pin_high;
	result_t result_d;

	// Stage 2 frees when empty or when its transfer completes
	assign advance     = !valid_s2 || result.ready;
	assign commit      = advance && valid_s1;
	assign item.ready  = !valid_s1 || advance;

	assign result.valid   = valid_s2;
	assign result.payload = result_s2;

	// Compute the register file after the stage-1 event
	always_comb begin
		select_d       = select_q;
		byte_waiting_d = byte_waiting_q;
		pending_d      = pending_q;
		last_word_d    = last_word_q;
		bandpass_d     = bandpass_q;
		prescaler_d    = prescaler_q;
		hiz_d          = hiz_q;
		gain_d         = gain_q;
		integ_d        = integ_q;
		channel_d      = channel_q;
		word_count_d   = word_count_q;
		txn_count_d    = txn_count_q;
		hold_d         = hold_q;
		hold_count_d   = hold_count_q;
		pin_high       = (item_s1.data_value != '0);

		case (cmd_t'(item_s1.cmd))
			CMD_SELECT: begin
				if (!pin_high && !select_q) begin
					// Open a transaction and drop any stale byte
					select_d       = 1'b1;
					byte_waiting_d = 1'b0;
					txn_count_d    = txn_count_q + CountW'(1);
				end else if (pin_high && select_q) begin
					// Close the transaction and decode the pending word
					select_d = 1'b0;
					if (byte_waiting_q) begin
						last_word_d  = pending_q;
						word_count_d = word_count_q + CountW'(1);
						case (target_t'(pending_q[7:6]))
							TGT_BANDPASS:  bandpass_d = pending_q[BandW-1:0];
							TGT_PRESCALER: begin
								prescaler_d = pending_q[PrescW:1];
								hiz_d       = pending_q[0];
							end
							TGT_GAIN:      gain_d = pending_q[GainW-1:0];
							default: begin
								if (pending_q[5] == TGT_EXT_INTEGRATOR) begin
									integ_d = pending_q[IntegW-1:0];
								end else begin
									channel_d = pending_q[0];
								end
							end
						endcase
					end
				end
			end
			CMD_BYTE: begin
				// Capture while selected; the last byte wins
				if (select_q) begin
					pending_d      = item_s1.data_value;
					byte_waiting_d = 1'b1;
				end
			end
			CMD_HOLD: begin
				if (pin_high != hold_q) begin
					hold_d       = pin_high;
					hold_count_d = hold_count_q + CountW'(1);
				end
			end
			default: begin
			end
		endcase

		result_d.bandpass_code   = bandpass_d;
		result_d.prescaler_code  = prescaler_d;
		result_d.output_hiz      = hiz_d;
		result_d.gain_code       = gain_d;
		result_d.integrator_code = integ_d;
		result_d.channel_sel     = channel_d;
		result_d.last_word       = last_word_d;
		result_d.word_count      = word_count_d;
		result_d.txn_count       = txn_count_d;
		result_d.hold_edge_count = hold_count_d;
		result_d.selected        = select_d;
		result_d.hold_level      = hold_d;
	end

	// Hold the pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
		if (commit) begin
			result_s2 <= result_d;
		end
	end

	// Update the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q       <= 1'b0;
			byte_waiting_q <= 1'b0;
			pending_q      <= '0;
			last_word_q    <= '0;
			bandpass_q     <= '0;
			prescaler_q    <= '0;
			hiz_q          <= 1'b0;
			gain_q         <= '0;
			integ_q        <= '0;
			channel_q      <= 1'b0;
			word_count_q   <= '0;
			txn_count_q    <= '0;
			hold_q         <= 1'b0;
			hold_count_q   <= '0;
		end else if (commit) begin
			select_q       <= select_d;
			byte_waiting_q <= byte_waiting_d;
			pending_q      <= pending_d;
			last_word_q    <= last_word_d;
			bandpass_q     <= bandpass_d;
			prescaler_q    <= prescaler_d;
			hiz_q          <= hiz_d;
			gain_q         <= gain_d;
			integ_q        <= integ_d;
			channel_q      <= channel_d;
			word_count_q   <= word_count_d;
			txn_count_q    <= txn_count_d;
			hold_q         <= hold_d;
			hold_count_q   <= hold_count_d;
		end
	end

endmodule
